// ===== sv/hsse_pkg.sv =====
// hsse_pkg: shared types, constants and the sector step classifier
// for the hall sector speed estimator; depends on nothing
package hsse_pkg;

   localparam int SectorCount   = 6;
   localparam int KWidth        = 31;
   localparam int TimeWidth     = 32;
   localparam int EstWidth      = 32;
   localparam int DivSteps      = KWidth;
   localparam int QueueDepthDef = 2;
   localparam logic [KWidth-1:0] KResetValue = 31'd2680830;

   // sector difference codes, current minus previous, modulo 16
   localparam logic [3:0] DiffPlusOne   = 4'd1;
   localparam logic [3:0] DiffMinusFive = 4'd11;
   localparam logic [3:0] DiffMinusOne  = 4'd15;
   localparam logic [3:0] DiffPlusFive  = 4'd5;

   typedef struct packed {
      logic [2:0]           sector_number;
      logic [TimeWidth-1:0] timestamp_ticks;
   } hsse_req_type;

   typedef struct packed {
      logic signed [EstWidth-1:0] pulsation_estimate;
      logic                       estimate_updated;
   } hsse_rsp_type;

   typedef enum logic [1:0] {
      OP_HOLD     = 2'd0,
      OP_FORWARD  = 2'd1,
      OP_BACKWARD = 2'd2
   } hsse_op_type;

   typedef struct packed {
      hsse_op_type          op;
      logic [TimeWidth-1:0] dt;
   } hsse_job_type;

   // previous sector is always a legal sector
   function automatic hsse_op_type classify_step(input logic [2:0] cur,
                                                 input logic [2:0] prev);
      logic [3:0] diff;
      hsse_op_type op;
      diff = {1'b0, cur} - {1'b0, prev};
      op   = OP_HOLD;
      if (cur < 3'(SectorCount)) begin
         if (diff == DiffPlusOne || diff == DiffMinusFive) begin
            op = OP_FORWARD;
         end else if (diff == DiffMinusOne || diff == DiffPlusFive) begin
            op = OP_BACKWARD;
         end
      end
      return op;
   endfunction

endpackage

// ===== sv/hsse_front.sv =====
// hsse_front: accepts samples, classifies the sector step and tracks the
// last sector and step time; depends on hsse_pkg
module hsse_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hsse_pkg::hsse_req_type req_data,
   output logic                  job_valid,
   output hsse_pkg::hsse_job_type job_data,
   input  logic                  queue_full
);
   import hsse_pkg::*;

   logic [2:0]           prev_sector_ff, prev_sector_in;
   logic [TimeWidth-1:0] prev_time_ff, prev_time_in;
   logic                 accept;
   hsse_op_type          op;
   logic [TimeWidth-1:0] dt_raw;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign op        = classify_step(req_data.sector_number, prev_sector_ff);
   assign dt_raw    = req_data.timestamp_ticks - prev_time_ff;

   assign job_valid   = accept;
   assign job_data.op = op;
   // zero elapsed time counts as one tick so the quotient saturates at k
   assign job_data.dt = (dt_raw == '0) ? TimeWidth'(1) : dt_raw;

   always_comb begin
      prev_sector_in = prev_sector_ff;
      prev_time_in   = prev_time_ff;
      if (accept && req_data.sector_number < 3'(SectorCount)) begin
         prev_sector_in = req_data.sector_number;
         if (op != OP_HOLD) begin
            prev_time_in = req_data.timestamp_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sector_ff <= '0;
         prev_time_ff   <= '0;
      end else begin
         prev_sector_ff <= prev_sector_in;
         prev_time_ff   <= prev_time_in;
      end
   end

endmodule

// ===== sv/hsse_queue.sv =====
// hsse_queue: small in-order queue of classified jobs between front and back
// depends on hsse_pkg
module hsse_queue #(
   parameter int Depth = hsse_pkg::QueueDepthDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  hsse_pkg::hsse_job_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output hsse_pkg::hsse_job_type head_data
);
   import hsse_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   hsse_job_type          slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CountWidth'(Depth));
   assign empty     = (count_ff == '0);
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/hsse_back.sv =====
// hsse_back: holds k, runs the bit-serial k / dt divide, keeps the held
// estimate and the result register; depends on hsse_pkg
module hsse_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [hsse_pkg::KWidth-1:0] csr_write_data,
   input  logic                  queue_empty,
   input  hsse_pkg::hsse_job_type queue_head,
   output logic                  queue_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hsse_pkg::hsse_rsp_type rsp_data
);
   import hsse_pkg::*;

   localparam int CountWidth = $clog2(DivSteps);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [KWidth-1:0]      k_ff, k_in;
   logic [TimeWidth-1:0]   divisor_ff, divisor_in;
   logic [TimeWidth-1:0]   rem_ff, rem_in;
   logic [KWidth-1:0]      dividend_ff, dividend_in;
   logic [KWidth-1:0]      quot_ff, quot_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   negate_ff, negate_in;
   logic [EstWidth-1:0]    held_ff, held_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hsse_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic [TimeWidth:0]     trial;
   logic [TimeWidth:0]     trial_diff;
   logic                   trial_ge;
   logic [EstWidth-1:0]    magnitude;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign trial      = {rem_ff, dividend_ff[KWidth-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge   = !trial_diff[TimeWidth];
   assign magnitude  = {{(EstWidth-KWidth){1'b0}}, quot_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = csr_write_enable ? csr_write_data : k_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      dividend_in  = dividend_ff;
      quot_in      = quot_ff;
      count_in     = count_ff;
      negate_in    = negate_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      queue_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               case (queue_head.op)
                  OP_FORWARD, OP_BACKWARD: begin
                     queue_pop   = 1'b1;
                     divisor_in  = queue_head.dt;
                     rem_in      = '0;
                     dividend_in = k_ff;
                     quot_in     = '0;
                     count_in    = '0;
                     negate_in   = (queue_head.op == OP_BACKWARD);
                     state_in    = ST_DIVIDE;
                  end
                  default: begin
                     // no step: repeat the held estimate
                     if (out_free) begin
                        queue_pop                      = 1'b1;
                        rsp_valid_in                   = 1'b1;
                        rsp_data_in.pulsation_estimate = held_ff;
                        rsp_data_in.estimate_updated   = 1'b0;
                     end
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            // restoring divide, one quotient bit per cycle
            rem_in      = trial_ge ? trial_diff[TimeWidth-1:0] : trial[TimeWidth-1:0];
            dividend_in = {dividend_ff[KWidth-2:0], 1'b0};
            quot_in     = {quot_ff[KWidth-2:0], trial_ge};
            count_in    = count_ff + 1'b1;
            if (count_ff == CountWidth'(DivSteps - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               held_in                        = negate_ff ? (~magnitude + 1'b1) : magnitude;
               rsp_valid_in                   = 1'b1;
               rsp_data_in.pulsation_estimate = held_in;
               rsp_data_in.estimate_updated   = 1'b1;
               state_in                       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= KResetValue;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      count_ff    <= count_in;
      negate_ff   <= negate_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sv/hall_sector_speed_estimator_core.sv =====
// Hall sector speed estimator core.
// Each req_ item carries a Hall sector (0..5) and a tick timestamp. A step
// to the next sector sets the estimate to +k / ticks since the last step,
// a step to the previous sector to -k / ticks; any other item repeats the
// held estimate. Every accepted item gives exactly one rsp_ item, in order,
// with estimate_updated set when a step produced a new value. Sectors 6
// and 7 leave all state unchanged.
// k is written through csr_write_enable / csr_write_data; the user is to
// write it only while idle: the block does not enforce it. A step item is
// loaded in ST_IDLE, divided bit-serially (k / dt) in ST_DIVIDE and
// finished in ST_FINISH; the back end takes no new item before then. Items
// without a step pass at one per cycle while rsp_stall is low. The front
// end keeps accepting until the job queue is full, then raises req_stall.
// When rsp_stall is high the result register holds its item and the back
// end waits to give its next result; the queue absorbs the next items.
// Synchronous reset returns k to its default, sector and step time to
// zero and the held estimate to zero, and empties the queue.
// Depends on hsse_pkg, hsse_front, hsse_queue and hsse_back.
module hall_sector_speed_estimator_core #(
   parameter int QueueDepth = hsse_pkg::QueueDepthDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hsse_pkg::hsse_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hsse_pkg::hsse_rsp_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [hsse_pkg::KWidth-1:0] csr_write_data
);
   import hsse_pkg::*;

   logic         job_valid;
   hsse_job_type job_data;
   logic         queue_full;
   logic         queue_empty;
   logic         queue_pop;
   hsse_job_type queue_head;

   hsse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .job_valid  (job_valid),
      .job_data   (job_data),
      .queue_full (queue_full)
   );

   hsse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_data  (job_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head_data  (queue_head)
   );

   hsse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_empty      (queue_empty),
      .queue_head       (queue_head),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
